// ===== sv/dve_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the delta varint encoder.
// No dependencies; used by dve_ctrl, dve_datapath and the top level.

package dve_pkg;

   localparam int ID_BITS = 32;

   localparam int FILE_ID_W  = 32;
   localparam int BYTE_W     = 8;
   localparam int GROUP_W    = 7;
   // Most groups emitted per identifier: four continuation bytes and the last one.
   localparam int MAX_BYTES  = 5;
   localparam int COUNT_W    = $clog2(MAX_BYTES);

   localparam logic [BYTE_W-1:0] CONT_BIT = 8'h80;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture a new identifier and form its delta
      logic emit;   // write the next group into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_group;   // the pending group is the final one for this item
   } status_type;

endpackage

// ===== sv/dve_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the delta varint encoder: previous-value register, delta
// shifter, group counter and output byte register. Depends on dve_pkg.

module dve_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  dve_pkg::cmd_type              cmd,
   output dve_pkg::status_type           status,
   input  logic [dve_pkg::FILE_ID_W-1:0] file_id,
   input  logic                          list_start,
   output logic [dve_pkg::BYTE_W-1:0]    out_byte,
   output logic                          last_byte
);

   logic [dve_pkg::ID_BITS-1:0] prev_ff, prev_in;
   logic [dve_pkg::ID_BITS-1:0] shift_ff, shift_in;
   logic [dve_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [dve_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                        last_ff, last_in;

   logic [dve_pkg::ID_BITS-1:0] next_id;
   logic [dve_pkg::ID_BITS-1:0] base;
   logic                        is_last;

   assign next_id = file_id[dve_pkg::ID_BITS-1:0] + dve_pkg::ID_BITS'(1);
   assign base    = list_start ? '0 : prev_ff;

   // Final group once the remainder fits in seven bits, or the group limit is hit.
   assign is_last = (shift_ff[dve_pkg::ID_BITS-1:dve_pkg::GROUP_W] == '0) ||
                    (count_ff == dve_pkg::COUNT_W'(dve_pkg::MAX_BYTES - 1));

   assign status.last_group = is_last;

   always_comb begin
      prev_in  = prev_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         prev_in  = next_id;
         shift_in = next_id - base;
         count_in = '0;
      end else if (cmd.emit) begin
         if (is_last) begin
            byte_in = shift_ff[dve_pkg::BYTE_W-1:0];
         end else begin
            byte_in = dve_pkg::CONT_BIT | {1'b0, shift_ff[dve_pkg::GROUP_W-1:0]};
         end
         last_in  = is_last;
         shift_in = shift_ff >> dve_pkg::GROUP_W;
         count_in = count_ff + dve_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      count_ff <= count_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

   assign out_byte  = byte_ff;
   assign last_byte = last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (count_ff < dve_pkg::COUNT_W'(dve_pkg::MAX_BYTES)))
      else $error("group counter past limit");

   a_emit_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (last_ff == !byte_ff[dve_pkg::BYTE_W-1]))
      else $error("continuation bit disagrees with last flag");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (count_ff == '0))
      else $error("group counter not cleared on load");

endmodule

// ===== sv/dve_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the delta varint encoder: state machine, input ready and
// output valid. Depends on dve_pkg.

module dve_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dve_pkg::cmd_type    cmd,
   input  dve_pkg::status_type status
);

   dve_pkg::state_type state_ff, state_in;
   logic               valid_ff, valid_in;
   logic               out_free;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         dve_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = dve_pkg::ST_EMIT;
            end
         end
         dve_pkg::ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (status.last_group) begin
                  state_in = dve_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = dve_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the byte until taken; refill on emit.
   assign valid_in = cmd.emit ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dve_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

   a_load_to_emit: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == dve_pkg::ST_EMIT))
      else $error("accepted item did not start emitting");

   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted byte not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && $past(cmd.emit) && valid_ff) |-> rsp_ready)
      else $error("output byte overwritten before taken");

endmodule

// ===== sv/delta_varint_encoder_top.sv =====
`timescale 1ns / 1ps
// Delta varint encoder top level: ties the controller and the datapath.
// Depends on dve_pkg, dve_ctrl and dve_datapath.

// Each accepted identifier yields (id+1) minus the previous id+1 (zero after
// list_start), modulo 2^32, sent as little-endian 7-bit groups, one byte per
// result item; bit 7 marks continuation and rsp_last_byte flags the final
// byte. An item is accepted in the idle state and its bytes are then emitted in order;
// no new item is accepted until its final byte is emitted. The single byte output
// register emits one group per cycle whenever the byte before it is taken or none is held.
// No configuration, no clearing pass after reset.

module delta_varint_encoder_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dve_pkg::FILE_ID_W-1:0] req_file_id,
   input  logic                          req_list_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dve_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_last_byte
);

   dve_pkg::cmd_type    cmd;
   dve_pkg::status_type status;

   dve_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   dve_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .file_id    (req_file_id),
      .list_start (req_list_start),
      .out_byte   (rsp_out_byte),
      .last_byte  (rsp_last_byte)
   );

endmodule

// ===== bench/delta_varint_encoder_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for delta_varint_encoder_top: queued identifiers, random idling,
// and a byte-level predictor of the delta varint stream. Depends on dve_pkg.

module delta_varint_encoder_top_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 120;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic [dve_pkg::FILE_ID_W-1:0] file_id;
      logic                          list_start;
      logic [3:0]                    gap;
   } id_item_type;

   typedef struct packed {
      logic [dve_pkg::BYTE_W-1:0] code;
      logic                       last;
   } varint_byte_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [dve_pkg::FILE_ID_W-1:0] req_file_id = '0;
   logic                          req_list_start = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [dve_pkg::BYTE_W-1:0]    rsp_out_byte;
   logic                          rsp_last_byte;

   id_item_type     pending_items[$];
   varint_byte_type expected_bytes[$];

   logic [dve_pkg::FILE_ID_W-1:0] prev_id_plus_one = '0;
   logic                          req_taken = 1'b0;
   logic                          rsp_taken = 1'b0;
   int                            error_count = 0;
   int                            ids_accepted = 0;
   int                            lists_seen = 0;
   int                            bytes_checked = 0;
   int                            queued_count = 0;

   // driver state
   logic [3:0]  gap_left = '0;
   logic        gap_loaded = 1'b0;
   id_item_type cur_item;

   // receiver state
   int   rsp_wait = 0;
   int   rsp_calm = 0;
   int   hold_left = 0;
   logic hold_request = 1'b0;
   logic hold_ack = 1'b0;

   int idle_cycles = 0;

   delta_varint_encoder_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_file_id    (req_file_id),
      .req_list_start (req_list_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Form (id+1) - previous, split it into 7-bit groups and queue the bytes.
   function automatic void predict_varint(input logic [dve_pkg::FILE_ID_W-1:0] id,
                                          input logic start);
      logic [dve_pkg::FILE_ID_W-1:0] base;
      logic [dve_pkg::FILE_ID_W-1:0] next_val;
      logic [dve_pkg::FILE_ID_W-1:0] delta;
      varint_byte_type               b;
      int                            n;
      base     = start ? '0 : prev_id_plus_one;
      next_val = id + 1'b1;
      delta    = next_val - base;
      n        = 0;
      while (delta >= dve_pkg::FILE_ID_W'(dve_pkg::CONT_BIT) &&
             n < dve_pkg::MAX_BYTES - 1) begin
         b.code = dve_pkg::CONT_BIT | {1'b0, delta[dve_pkg::GROUP_W-1:0]};
         b.last = 1'b0;
         expected_bytes = {expected_bytes, b};
         delta = delta >> dve_pkg::GROUP_W;
         n++;
      end
      b.code = delta[dve_pkg::BYTE_W-1:0];
      b.last = 1'b1;
      expected_bytes = {expected_bytes, b};
      prev_id_plus_one = next_val;
   endfunction

   // Check the oldest expected byte first, then record any newly accepted identifier.
   always @(posedge clock) begin
      varint_byte_type want;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual byte %02h last %b",
                     $time, rsp_out_byte, rsp_last_byte);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.code) begin
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, want.code, rsp_out_byte);
               error_count++;
            end
            if (rsp_last_byte !== want.last) begin
               $display("%0t: last_byte mismatch: expected %b, actual %b",
                        $time, want.last, rsp_last_byte);
               error_count++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         ids_accepted++;
         if (req_list_start) lists_seen++;
         predict_varint(req_file_id, req_list_start);
      end
   end

   // Sender: wait out each item's gap, then hold valid until the item is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the current item
      end else if (pending_items.size() == 0) begin
         req_valid <= 1'b0;
      end else if (!gap_loaded && pending_items[0].gap != 0) begin
         req_valid  <= 1'b0;
         gap_left   <= pending_items[0].gap - 1'b1;
         gap_loaded <= 1'b1;
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1'b1;
      end else begin
         cur_item = pending_items.pop_front();
         req_valid      <= 1'b1;
         req_file_id    <= cur_item.file_id;
         req_list_start <= cur_item.list_start;
         gap_loaded     <= 1'b0;
      end
   end

   // Receiver: random stall after each byte, calm stretches, and one long hold on request.
   always @(negedge clock) begin
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request != hold_ack) begin
         hold_ack  <= hold_request;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_taken) begin
         if (rsp_calm != 0) begin
            w = 0;
            rsp_calm <= rsp_calm - 1;
         end else begin
            w = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0) rsp_calm <= 30;
         end
         rsp_ready <= (w == 0);
         rsp_wait  <= w;
      end else if (!rsp_ready) begin
         if (rsp_wait <= 1) begin
            rsp_ready <= 1'b1;
            rsp_wait  <= 0;
         end else begin
            rsp_wait <= rsp_wait - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d bytes still expected",
                     $time, WATCHDOG_LIMIT, expected_bytes.size());
            $display("delta_varint_encoder_top_tb failed");
            $finish;
         end
      end
   end

   task automatic queue_id(input logic [dve_pkg::FILE_ID_W-1:0] id, input logic start,
                           input bit quiet);
      id_item_type it;
      it.file_id    = id;
      it.list_start = start;
      it.gap        = quiet ? 4'd0 : 4'($urandom_range(0, 9));
      pending_items = {pending_items, it};
      queued_count++;
   endtask

   // Mostly short deltas, some mid-sized, a few of any width.
   function automatic logic [dve_pkg::FILE_ID_W-1:0] rand_step();
      int     sel;
      int     w;
      longint m;
      sel = $urandom_range(0, 19);
      if (sel < 11) w = $urandom_range(0, 7);
      else if (sel < 16) w = $urandom_range(8, 14);
      else w = $urandom_range(15, 32);
      m = (64'd1 << w) - 1;
      return dve_pkg::FILE_ID_W'($urandom & m);
   endfunction

   // One mostly ascending posting list with random content, repeats and backward steps, sprinkled with noise.
   task automatic queue_list(input int len, input bit quiet);
      logic [dve_pkg::FILE_ID_W-1:0] id;
      int                            k;
      id = ($urandom_range(0, 1) == 0) ?
           dve_pkg::FILE_ID_W'($urandom_range(0, 1000)) : $urandom;
      for (k = 0; k < len; k++) begin
         if (k != 0 && $urandom_range(0, 7) == 0) begin
            queue_id($urandom, 1'($urandom_range(0, 1)), quiet);
         end else begin
            queue_id(id, k == 0, quiet);
         end
         case ($urandom_range(0, 15))
            0:       id = id;                // repeat
            1:       id = id - rand_step();  // unsorted
            default: id = id + rand_step() + 1'b1;
         endcase
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      #1;
      while (pending_items.size() != 0 || req_valid || expected_bytes.size() != 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: group boundaries, zero delta, all-ones id, unsorted ids.
      queue_id(32'h0000_0000, 1'b1, 1'b0);   // delta 1
      queue_id(32'h0000_0000, 1'b0, 1'b0);   // repeat: delta 0
      queue_id(32'h0000_007E, 1'b1, 1'b0);   // 0x7F, one byte
      queue_id(32'h0000_007F, 1'b1, 1'b0);   // 0x80, two bytes
      queue_id(32'h0000_3FFE, 1'b1, 1'b0);
      queue_id(32'h0000_3FFF, 1'b1, 1'b0);
      queue_id(32'h001F_FFFE, 1'b1, 1'b0);
      queue_id(32'h001F_FFFF, 1'b1, 1'b0);
      queue_id(32'h0FFF_FFFE, 1'b1, 1'b0);
      queue_id(32'h0FFF_FFFF, 1'b1, 1'b0);
      queue_id(32'hFFFF_FFFE, 1'b1, 1'b0);   // largest delta, five bytes
      queue_id(32'hFFFF_FFFF, 1'b1, 1'b0);   // id+1 wraps to zero: delta 0
      queue_id(32'h0000_0000, 1'b0, 1'b0);   // previous stored as zero
      queue_id(32'h0000_0005, 1'b0, 1'b1);
      queue_id(32'h0000_0002, 1'b0, 1'b1);   // unsorted: delta wraps
      queue_id(32'hFFFF_FFFF, 1'b0, 1'b1);
      queue_id(32'hAAAA_AAAA, 1'b0, 1'b0);
      queue_id(32'h5555_5555, 1'b1, 1'b0);
      queue_id(32'h8000_0000, 1'b0, 1'b0);
      queue_id(32'h8000_0000, 1'b1, 1'b0);
      wait_drained();

      // Long receiver hold while a full batch is offered.
      hold_request = ~hold_request;
      while (queued_count < 70) queue_list($urandom_range(3, 8), 1'b0);
      wait_drained();

      while (queued_count < 150) queue_list($urandom_range(2, 10), $urandom_range(0, 4) == 0);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Encoded %0d identifiers over %0d list starts; %0d bytes compared.",
               ids_accepted, lists_seen, bytes_checked);
      $display("Covered 1- to 5-byte deltas, zero and wrapped deltas, and long output stalls.");
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("delta_varint_encoder_top_tb passed");
      end else begin
         $display("delta_varint_encoder_top_tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/dve_pkg.sv
sv/dve_datapath.sv
sv/dve_ctrl.sv
sv/delta_varint_encoder_top.sv
bench/delta_varint_encoder_top_tb.sv
